// ----- sv/pssq_pkg.sv -----
package pssq_pkg;

  localparam int unsigned BLOCK_COUNT_DEF = 12;
  localparam int unsigned BLK_IDX_W       = 4;
  localparam int unsigned PIN_W           = 5;
  localparam int unsigned CMP_W           = 16;
  localparam int unsigned POS_W           = 8;

  localparam int unsigned SPACING      = 50;
  localparam int unsigned POS_MAX      = 255;
  localparam int unsigned OFFSET       = POS_MAX + SPACING;
  localparam int unsigned LOOP_SPACING = SPACING + SPACING;
  localparam int unsigned LOOP_PERIOD  = OFFSET + POS_MAX + (SPACING / 2);
  localparam int unsigned CMP_MAX      = 32'h0000_ffff;
  localparam int unsigned CMP_MIN      = 5;

  // Phase codes
  localparam logic [1:0] PH_A_ON  = 2'd0;
  localparam logic [1:0] PH_B_ON  = 2'd1;
  localparam logic [1:0] PH_A_OFF = 2'd2;
  localparam logic [1:0] PH_B_OFF = 2'd3;

  // Op codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_MATCH = 1'b1;

  typedef struct packed {
    logic             op;
    logic [CMP_W-1:0] timer_now;
    logic [POS_W-1:0] pos_a;
    logic             servo_a;
    logic [POS_W-1:0] pos_b;
    logic             servo_b;
  } item_t;

  typedef struct packed {
    logic             pin_valid;
    logic [PIN_W-1:0] pin_number;
    logic             pin_level;
    logic [CMP_W-1:0] compare_value;
    logic             busy_res;
    logic             counter_restart;
  } result_t;

  typedef struct packed {
    logic [1:0]           phase;
    logic [BLK_IDX_W-1:0] block_index;
    logic                 busy;
  } status_t;

  // Scale by 8 with clamp, add base with wrap, floor at the minimum
  function automatic logic [CMP_W-1:0] calc_compare(input logic [CMP_W-1:0] v,
                                                    input logic [CMP_W-1:0] base);
    logic [CMP_W-1:0] vc;
    logic [CMP_W+2:0] sc;
    logic [CMP_W:0]   t;
    vc = (v == '0) ? CMP_W'(1) : v;
    sc = {vc, 3'b000};
    if (sc > (CMP_W+3)'(CMP_MAX)) begin
      sc = (CMP_W+3)'(CMP_MAX);
    end
    t = {1'b0, sc[CMP_W-1:0]} + {1'b0, base};
    if (t > (CMP_W+1)'(CMP_MAX)) begin
      t = t - (CMP_W+1)'(CMP_MAX);
    end
    if (t < (CMP_W+1)'(CMP_MIN)) begin
      return CMP_W'(CMP_MIN);
    end
    return t[CMP_W-1:0];
  endfunction

endpackage

// ----- sv/pssq_core.sv -----
module pssq_core
  import pssq_pkg::*;
#(
  parameter int unsigned BLOCK_COUNT = BLOCK_COUNT_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t res,
  output status_t status
);

  localparam int unsigned BLK_W = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;

  logic [1:0]           phase;
  logic [BLK_IDX_W-1:0] block_index;
  logic                 busy;
  logic [BLOCK_COUNT-1:0] blk_valid;
  logic [POS_W-1:0]     pos_a_reg [BLOCK_COUNT];
  logic [POS_W-1:0]     pos_b_reg [BLOCK_COUNT];

  logic [BLK_W-1:0]     idx;
  logic [BLK_IDX_W:0]   idx_inc;
  logic [BLK_IDX_W-1:0] idx_next;
  logic [POS_W-1:0]     pa_eff;
  logic [POS_W-1:0]     pb_eff;
  logic [CMP_W-1:0]     cmp_b_on;
  logic [CMP_W-1:0]     cmp_a_off;
  logic [CMP_W-1:0]     cmp_finish;
  logic [PIN_W-1:0]     pin_a;
  logic [PIN_W-1:0]     pin_b;
  logic [1:0]           phase_next;
  logic [BLK_IDX_W-1:0] block_index_next;
  logic                 busy_next;

  assign idx      = block_index[BLK_W-1:0];
  assign idx_inc  = {1'b0, block_index} + (BLK_IDX_W+1)'(1);
  assign idx_next = (idx_inc >= (BLK_IDX_W+1)'(BLOCK_COUNT)) ? '0 : idx_inc[BLK_IDX_W-1:0];
  assign pa_eff   = item.servo_a ? item.pos_a : '0;
  assign pb_eff   = item.servo_b ? item.pos_b : '0;
  assign pin_a    = PIN_W'(block_index);
  assign pin_b    = PIN_W'(block_index) + PIN_W'(BLOCK_COUNT);

  // A block never computed since reset reads as all-zero compares
  always_comb begin
    cmp_b_on   = '0;
    cmp_a_off  = '0;
    cmp_finish = '0;
    if (blk_valid[idx]) begin
      cmp_b_on   = calc_compare(CMP_W'(LOOP_SPACING + LOOP_PERIOD - OFFSET)
                                - CMP_W'(pos_b_reg[idx]), '0);
      cmp_a_off  = calc_compare(CMP_W'(LOOP_SPACING + OFFSET)
                                + CMP_W'(pos_a_reg[idx]), '0);
      cmp_finish = calc_compare(CMP_W'(LOOP_SPACING + LOOP_PERIOD), '0);
    end
  end

  always_comb begin
    res              = '0;
    phase_next       = phase;
    block_index_next = block_index;
    busy_next        = busy;
    if (item.op == OP_START) begin
      phase_next        = PH_A_ON;
      block_index_next  = '0;
      res.compare_value = calc_compare(CMP_W'(LOOP_SPACING), item.timer_now);
    end else begin
      res.pin_valid = 1'b1;
      case (phase)
        PH_A_ON: begin
          busy_next         = 1'b1;
          res.pin_number    = pin_a;
          res.pin_level     = 1'b1;
          res.compare_value = cmp_b_on;
          phase_next        = PH_B_ON;
        end
        PH_B_ON: begin
          res.pin_number    = pin_b;
          res.pin_level     = 1'b1;
          res.compare_value = cmp_a_off;
          phase_next        = PH_A_OFF;
        end
        PH_A_OFF: begin
          res.pin_number    = pin_a;
          res.pin_level     = 1'b0;
          res.compare_value = cmp_finish;
          phase_next        = PH_B_OFF;
        end
        default: begin
          res.pin_number      = pin_b;
          res.pin_level       = 1'b0;
          busy_next           = 1'b0;
          block_index_next    = idx_next;
          res.counter_restart = 1'b1;
          res.compare_value   = calc_compare(CMP_W'(LOOP_SPACING), '0);
          phase_next          = PH_A_ON;
        end
      endcase
    end
    res.busy_res = busy_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_A_ON;
      block_index <= '0;
      busy        <= 1'b0;
      blk_valid   <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      block_index <= block_index_next;
      busy        <= busy_next;
      // Capture the next block's positions on the B-off event
      if (item.op == OP_MATCH && phase == PH_B_OFF) begin
        blk_valid[idx_next[BLK_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && item.op == OP_MATCH && phase == PH_B_OFF) begin
      pos_a_reg[idx_next[BLK_W-1:0]] <= pa_eff;
      pos_b_reg[idx_next[BLK_W-1:0]] <= pb_eff;
    end
  end

  assign status.phase       = phase;
  assign status.block_index = block_index;
  assign status.busy        = busy;

endmodule

// ----- sv/paired_servo_pulse_sequencer_top.sv -----
// Paired servo pulse sequencer.
// Input stream (s_*): one item per timer event. s_tuser[0] is the op (start
// or compare match); s_tdata carries the captured counter and the positions
// and servo flags of the next block. Output stream (m_*): one result item per
// input item with the pin to switch, its level, the next compare value, the
// busy flag and the counter-restart flag.
// The result passes through two registers: the input register, then the result
// register. Throughput: one item per cycle while the receiver does not stall.
// Reset clears the phase to A on, the block index to 0, busy to 0 and marks
// every block as not yet computed, so its compares read as 0; both pipeline
// registers empty.
// When the receiver stalls, the result register holds its item, the input
// register can still take one more item, and then s_tready drops until
// m_tready returns. No item is lost or repeated.
module paired_servo_pulse_sequencer_top
  import pssq_pkg::*;
#(
  parameter int unsigned BLOCK_COUNT = BLOCK_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] timer_now, [23:16] pos_a, [24] servo_a, [32:25] pos_b,
  // [33] servo_b, [39:34] zero
  input  logic [39:0] s_tdata,
  // [0] op
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] pin_valid, [5:1] pin_number, [6] pin_level, [22:7] compare_value,
  // [23] busy_res, [24] counter_restart, [31:25] zero
  output logic [31:0] m_tdata
);

  logic    v1;
  item_t   item1;
  item_t   item_in;
  logic    adv2;
  logic    fire;
  result_t core_res;
  result_t res;
  status_t status;

  assign item_in.op        = s_tuser[0];
  assign item_in.timer_now = s_tdata[15:0];
  assign item_in.pos_a     = s_tdata[23:16];
  assign item_in.servo_a   = s_tdata[24];
  assign item_in.pos_b     = s_tdata[32:25];
  assign item_in.servo_b   = s_tdata[33];

  assign adv2     = !m_tvalid || m_tready;
  assign fire     = v1 && adv2;
  assign s_tready = !v1 || adv2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      v1 <= 1'b1;
    end else if (fire) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item1 <= item_in;
    end
  end

  pssq_core #(
    .BLOCK_COUNT(BLOCK_COUNT)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item1),
    .res    (core_res),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv2) begin
      m_tvalid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= core_res;
    end
  end

  assign m_tdata = {7'b0, res.counter_restart, res.busy_res, res.compare_value,
                    res.pin_level, res.pin_number, res.pin_valid};

  // Busy is set on A on and cleared only on B off
  assert property (@(posedge clk) disable iff (rst)
    status.phase != PH_A_ON |-> status.busy)
    else $error("sequence mid-pulse without busy");

  assert property (@(posedge clk) disable iff (rst)
    {1'b0, status.block_index} < (BLK_IDX_W+1)'(BLOCK_COUNT))
    else $error("block index out of range");

  // A counter restart comes only with the B-off pin action and loop spacing
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.counter_restart |->
      res.pin_valid && !res.pin_level && !res.busy_res &&
      res.compare_value == calc_compare(CMP_W'(LOOP_SPACING), '0))
    else $error("bad counter restart item");

  // A full pipeline under a stall must refuse new items
  assert property (@(posedge clk) disable iff (rst)
    v1 && m_tvalid && !m_tready |-> !s_tready && !fire)
    else $error("item taken while pipeline full");

endmodule

// ----- tb/sv/pssq_pulse_checker.sv -----
`timescale 1ns / 100ps
module pssq_pulse_checker
  import pssq_pkg::*;
#(
  parameter int unsigned BLOCK_COUNT = BLOCK_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  output int          mismatch_cnt,
  output int          pending_cnt,
  output int          action_cnt,
  output int          restart_cnt
);

  localparam int unsigned CMP_SCALE = 8;

  logic [1:0]       seq_phase;
  int unsigned      cur_block;
  logic [CMP_W-1:0] b_on_tbl   [BLOCK_COUNT];
  logic [CMP_W-1:0] a_off_tbl  [BLOCK_COUNT];
  logic [CMP_W-1:0] finish_tbl [BLOCK_COUNT];
  logic             busy_st;
  result_t          pin_action_q [$];
  int               errs;
  int               checked;
  int               restarts;

  function automatic logic [CMP_W-1:0] scaled_compare(int unsigned v, int unsigned base);
    int unsigned t;
    if (v < 1) begin
      v = 1;
    end
    v = v * CMP_SCALE;
    if (v > CMP_MAX) begin
      v = CMP_MAX;
    end
    t = v + (base & CMP_MAX);
    // wrap past the counter top
    if (t > CMP_MAX) begin
      t = t - CMP_MAX;
    end
    if (t < CMP_MIN) begin
      return CMP_W'(CMP_MIN);
    end
    return CMP_W'(t);
  endfunction

  // Advance the sequencer by one item and return the pin action it causes
  function automatic result_t next_pin_action(logic op, logic [CMP_W-1:0] now,
                                              logic [POS_W-1:0] pa_raw, logic sa,
                                              logic [POS_W-1:0] pb_raw, logic sb);
    result_t     r;
    int unsigned pa;
    int unsigned pb;
    int unsigned idx;
    r   = '0;
    pa  = sa ? pa_raw : 0;
    pb  = sb ? pb_raw : 0;
    idx = (cur_block >= BLOCK_COUNT) ? 0 : cur_block;
    if (op == OP_START) begin
      seq_phase = PH_A_ON;
      cur_block = 0;
      r.compare_value = scaled_compare(LOOP_SPACING, now);
    end else begin
      r.pin_valid = 1'b1;
      case (seq_phase)
        PH_A_ON: begin
          busy_st = 1'b1;
          r.pin_number = PIN_W'(idx);
          r.pin_level = 1'b1;
          r.compare_value = b_on_tbl[idx];
          seq_phase = PH_B_ON;
        end
        PH_B_ON: begin
          r.pin_number = PIN_W'(idx + BLOCK_COUNT);
          r.pin_level = 1'b1;
          r.compare_value = a_off_tbl[idx];
          seq_phase = PH_A_OFF;
        end
        PH_A_OFF: begin
          r.pin_number = PIN_W'(idx);
          r.pin_level = 1'b0;
          r.compare_value = finish_tbl[idx];
          seq_phase = PH_B_OFF;
        end
        default: begin
          r.pin_number = PIN_W'(idx + BLOCK_COUNT);
          r.pin_level = 1'b0;
          busy_st = 1'b0;
          // move to the next block and load its three compares
          idx = (idx + 1 >= BLOCK_COUNT) ? 0 : idx + 1;
          cur_block = idx;
          r.counter_restart = 1'b1;
          b_on_tbl[idx]   = scaled_compare(LOOP_SPACING + LOOP_PERIOD - (OFFSET + pb), 0);
          a_off_tbl[idx]  = scaled_compare(LOOP_SPACING + OFFSET + pa, 0);
          finish_tbl[idx] = scaled_compare(LOOP_SPACING + LOOP_PERIOD, 0);
          r.compare_value = scaled_compare(LOOP_SPACING, 0);
          seq_phase = PH_A_ON;
        end
      endcase
    end
    r.busy_res = busy_st;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [CMP_W-1:0] want,
                             input logic [CMP_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      seq_phase = PH_A_ON;
      cur_block = 0;
      busy_st   = 1'b0;
      for (int i = 0; i < BLOCK_COUNT; i++) begin
        b_on_tbl[i]   = '0;
        a_off_tbl[i]  = '0;
        finish_tbl[i] = '0;
      end
      pin_action_q.delete();
      errs     = 0;
      checked  = 0;
      restarts = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        pin_action_q.push_back(next_pin_action(s_tuser[0], s_tdata[15:0], s_tdata[23:16],
                                               s_tdata[24], s_tdata[32:25], s_tdata[33]));
      end
      if (m_tvalid && m_tready) begin
        if (pin_action_q.size() == 0) begin
          $error("result item with nothing pending: m_tdata=%h", m_tdata);
          errs++;
        end else begin
          want = pin_action_q.pop_front();
          checked++;
          if (m_tdata[24]) begin
            restarts++;
          end
          check_field("pin_valid", CMP_W'(want.pin_valid), CMP_W'(m_tdata[0]));
          check_field("pin_number", CMP_W'(want.pin_number), CMP_W'(m_tdata[5:1]));
          check_field("pin_level", CMP_W'(want.pin_level), CMP_W'(m_tdata[6]));
          check_field("compare_value", want.compare_value, m_tdata[22:7]);
          check_field("busy_res", CMP_W'(want.busy_res), CMP_W'(m_tdata[23]));
          check_field("counter_restart", CMP_W'(want.counter_restart),
                      CMP_W'(m_tdata[24]));
        end
      end
    end
    mismatch_cnt <= errs;
    pending_cnt  <= pin_action_q.size();
    action_cnt   <= checked;
    restart_cnt  <= restarts;
  end

endmodule

// ----- tb/sv/paired_servo_pulse_sequencer_top_tb.sv -----
`timescale 1ns / 100ps
module paired_servo_pulse_sequencer_top_tb;
  import pssq_pkg::*;

  localparam int unsigned LIMIT        = 400_000;
  localparam int unsigned RANDOM_ITEMS = 650;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [39:0] s_tdata  = '0;
  logic [0:0]  s_tuser  = '0;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [31:0] m_tdata;

  int          mismatch_cnt;
  int          pending_cnt;
  int          action_cnt;
  int          restart_cnt;
  int unsigned cycles    = 0;
  int unsigned start_cnt = 0;
  int unsigned match_cnt = 0;
  int unsigned rdy_hold  = 0;
  bit          calm      = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  paired_servo_pulse_sequencer_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  pssq_pulse_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .mismatch_cnt (mismatch_cnt),
    .pending_cnt  (pending_cnt),
    .action_cnt   (action_cnt),
    .restart_cnt  (restart_cnt)
  );

  // Mostly no gap, some short ones, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 65) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(3, 1);
    end
    if (r < 98) begin
      return $urandom_range(12, 4);
    end
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) begin
      return '0;
    end
    if (r == 1) begin
      return '1;
    end
    return POS_W'($urandom);
  endfunction

  // Lean toward the top of the counter where the start compare wraps
  function automatic logic [CMP_W-1:0] rand_now();
    if ($urandom_range(4) == 0) begin
      return CMP_W'($urandom_range(65535, 64730));
    end
    return CMP_W'($urandom);
  endfunction

  always @(negedge clk) begin
    int unsigned n;
    if (rdy_hold != 0) begin
      rdy_hold--;
    end else if (m_tready) begin
      n = idle_len();
      if (n != 0) begin
        m_tready = 1'b0;
        rdy_hold = n - 1;
      end
    end else begin
      m_tready = 1'b1;
      rdy_hold = $urandom_range(15);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [CMP_W-1:0] now,
                           input logic [POS_W-1:0] pa, input logic sa,
                           input logic [POS_W-1:0] pb, input logic sb);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tuser  = op;
    s_tdata  = {6'b0, sb, pb, sa, pa, now};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (op == OP_START) begin
      start_cnt++;
    end else begin
      match_cnt++;
    end
  endtask

  task automatic send_start(input logic [CMP_W-1:0] now);
    send_item(OP_START, now, rand_pos(), 1'($urandom), rand_pos(), 1'($urandom));
  endtask

  task automatic send_match(input logic [POS_W-1:0] pa, input logic sa,
                            input logic [POS_W-1:0] pb, input logic sb);
    send_item(OP_MATCH, CMP_W'($urandom), pa, sa, pb, sb);
  endtask

  initial begin
    int unsigned k;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // block 0 has never been computed: its compares read as zero
    repeat (3) send_match(rand_pos(), 1'b1, rand_pos(), 1'b1);
    send_match(8'd255, 1'b1, 8'd0, 1'b1);
    repeat (3) send_match(rand_pos(), 1'b1, rand_pos(), 1'b1);
    send_match(8'd0, 1'b1, 8'd255, 1'b1);
    // pins not in servo mode count as position zero
    repeat (3) send_match(rand_pos(), 1'b1, rand_pos(), 1'b1);
    send_match(8'd255, 1'b0, 8'd255, 1'b0);
    // start compare: no wrap, wrap to the floor, wrap above the floor
    send_start(16'd0);
    send_start(16'hffff);
    send_start(16'd64735);
    send_start(16'd64736);
    send_start(16'd64739);
    send_start(16'd64740);
    // restart in the middle of a pulse section
    repeat (2) send_match(rand_pos(), 1'b1, rand_pos(), 1'b1);
    send_start(16'd64737);

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 200) begin
        calm = 1'b1;
      end
      if (k == 300) begin
        calm = 1'b0;
      end
      // hold off until the pipeline has drained
      if (k == 400) begin
        s_tvalid = 1'b0;
        wait (pending_cnt == 0);
        @(negedge clk);
      end
      if ($urandom_range(99) < 3) begin
        send_start(rand_now());
      end else begin
        send_match(rand_pos(), 1'($urandom_range(99) < 85), rand_pos(),
                   1'($urandom_range(99) < 85));
      end
    end

    s_tvalid = 1'b0;
    wait (pending_cnt == 0);
    repeat (10) @(posedge clk);
    $display("Sent %0d start commands and %0d compare events; %0d results checked.",
             start_cnt, match_cnt, action_cnt);
    $display("Block advances with counter restart: %0d; mismatches: %0d.",
             restart_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/pssq_pkg.sv
sv/pssq_core.sv
sv/paired_servo_pulse_sequencer_top.sv
tb/sv/pssq_pulse_checker.sv
tb/sv/paired_servo_pulse_sequencer_top_tb.sv
